// ===== hdl/sgp_pkg.sv =====
// Package for the serial gamepad poller: item types and register map.
// No dependencies.
package sgp_pkg;

  localparam int unsigned PeriodW = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned OutButtonsW = 8;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned RegIdxW = 1;

  localparam logic [RegIdxW-1:0] RegPeriodUs = 1'b0;
  localparam logic [PeriodW-1:0] PeriodReset = 16'd24;

  typedef struct packed {
    logic [TimeW-1:0] time_us;
    logic             data_in;
  } in_t;

  typedef struct packed {
    logic                   latch_out;
    logic                   clock_out;
    logic [OutButtonsW-1:0] buttons;
    logic [OutButtonsW-1:0] changed;
  } out_t;

endpackage

// ===== hdl/serial_gamepad_poller.sv =====
// Serial gamepad poller: input register, combinational state update, result register.
// Depends on sgp_pkg.
//
// Polls a serial shift-register game controller. Every input item carries the
// current microsecond time and the data pin level; when more than period_us/2
// microseconds have passed since the last toggle, the phase flips, driving the
// latch pulse and then one clock pulse per button while the inverted data bit
// is captured. Each item yields exactly one result item holding both line
// levels, the button bits and the changed mask. The block takes one item per
// clock cycle unless stalled; an item passes the input register, then the result
// register, and the state update between them is a 32-bit subtract and compare.
// The input is stalled only while the result register is full and stalled.
module serial_gamepad_poller
  import sgp_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_t                out_data_o
);

  localparam int unsigned SlotW = $clog2(NUM_BUTTONS + 1);
  localparam int unsigned WideW = (NUM_BUTTONS > OutButtonsW) ? NUM_BUTTONS : OutButtonsW;
  localparam logic [SlotW-1:0] SlotLast = SlotW'(NUM_BUTTONS);

  logic [PeriodW-1:0]     period_q;
  logic                   s1_valid_q;
  in_t                    s1_data_q;
  logic                   out_valid_q;
  out_t                   out_data_q, out_data_d;
  logic [TimeW-1:0]       last_time_q, last_time_d;
  logic                   phase_q, phase_d;
  logic [SlotW-1:0]       slot_q, slot_d;
  logic [NUM_BUTTONS-1:0] bits_q, bits_d;
  logic [NUM_BUTTONS-1:0] prev_q, prev_d;
  logic                   latch_q, latch_d;
  logic                   clock_q, clock_d;
  logic                   adv_out;
  logic                   adv_in;
  logic                   cfg_wr;
  logic [TimeW-1:0]       elapsed;
  logic                   toggle;
  logic [SlotW-1:0]       slot_inc;
  logic [WideW-1:0]       bits_wide;
  logic [WideW-1:0]       chg_wide;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    if (paddr[ApbAddrW-1 -: RegIdxW] == RegPeriodUs) begin
      prdata = ApbDataW'(period_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PeriodReset;
    end else if (cfg_wr && paddr[ApbAddrW-1 -: RegIdxW] == RegPeriodUs) begin
      period_q <= pwdata[PeriodW-1:0];
    end
  end

  assign adv_out    = !out_valid_q || !out_stall_i;
  assign adv_in     = !s1_valid_q || adv_out;
  assign in_stall_o = !adv_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv_in) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in && in_valid_i) begin
      s1_data_q <= in_data_i;
    end
  end

  assign elapsed  = s1_data_q.time_us - last_time_q;
  assign toggle   = elapsed > TimeW'(period_q >> 1);
  assign slot_inc = (slot_q >= SlotLast) ? '0 : slot_q + SlotW'(1);

  always_comb begin
    last_time_d = last_time_q;
    phase_d     = phase_q;
    slot_d      = slot_q;
    bits_d      = bits_q;
    prev_d      = prev_q;
    latch_d     = latch_q;
    clock_d     = clock_q;
    if (toggle) begin
      last_time_d = s1_data_q.time_us;
      phase_d     = !phase_q;
      if (!phase_q) begin
        slot_d = slot_inc;
        if (slot_inc == '0) begin
          latch_d = 1'b1;
        end else begin
          clock_d = 1'b1;
          for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (slot_inc == SlotW'(i + 1)) begin
              prev_d[i] = bits_q[i];
              bits_d[i] = !s1_data_q.data_in;
            end
          end
        end
      end else if (slot_q == '0) begin
        latch_d = 1'b0;
      end else begin
        clock_d = 1'b0;
      end
    end
  end

  assign bits_wide = WideW'(bits_d);
  assign chg_wide  = WideW'(bits_d ^ prev_d);

  always_comb begin
    out_data_d.latch_out = latch_d;
    out_data_d.clock_out = clock_d;
    out_data_d.buttons   = bits_wide[OutButtonsW-1:0];
    out_data_d.changed   = chg_wide[OutButtonsW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_time_q <= '0;
      phase_q     <= 1'b0;
      slot_q      <= '0;
      bits_q      <= '0;
      prev_q      <= '0;
      latch_q     <= 1'b0;
      clock_q     <= 1'b0;
    end else if (adv_out && s1_valid_q) begin
      last_time_q <= last_time_d;
      phase_q     <= phase_d;
      slot_q      <= slot_d;
      bits_q      <= bits_d;
      prev_q      <= prev_d;
      latch_q     <= latch_d;
      clock_q     <= clock_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_out) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out && s1_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_lines_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.latch_out && out_data_o.clock_out))
    else $error("latch and clock lines high together");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SlotLast)
    else $error("slot counter out of range");

  a_latch_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    latch_q |-> slot_q == '0)
    else $error("latch high outside slot zero");

  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> !in_stall_o)
    else $error("input stalled with empty result register");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |=> $stable(slot_q) && $stable(phase_q))
    else $error("state changed without an item");
`endif

endmodule

// ===== test/serial_gamepad_poller_tb.sv =====
// Testbench for serial_gamepad_poller: drives timed data pin items, predicts each
// report from its own poller state copy and checks results in order.
// Depends on sgp_pkg and the serial_gamepad_poller RTL.
`timescale 1ns / 1ps

module serial_gamepad_poller_tb
  import sgp_pkg::*;
();

  localparam int unsigned NumButtons = 8;
  localparam int unsigned HoldCycles = 80;
  localparam logic [ApbAddrW-1:0] PeriodAddr = ApbAddrW'(RegPeriodUs) << 2;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_stall_o;
  in_t                 in_data_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_t                out_data_o;

  serial_gamepad_poller #(
    .NUM_BUTTONS(NumButtons)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predicted poller state
  logic [PeriodW-1:0]    pr_period;
  logic [TimeW-1:0]      pr_last;
  logic                  pr_phase;
  int unsigned           pr_slot;
  logic [NumButtons-1:0] pr_buttons;
  logic [NumButtons-1:0] pr_prev;
  logic                  pr_latch;
  logic                  pr_clock;

  out_t        expected_reports[$];
  out_t        want_report;
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left      = 0;
  logic        hold_start     = 1'b0;
  logic [TimeW-1:0] poll_now  = '0;

  function automatic out_t poll_step(input in_t item);
    logic [TimeW-1:0]      elapsed;
    logic [NumButtons-1:0] diff;
    out_t                  res;
    elapsed = item.time_us - pr_last;
    if (elapsed > TimeW'(pr_period >> 1)) begin
      pr_phase = ~pr_phase;
      if (pr_phase) begin
        pr_slot = (pr_slot >= NumButtons) ? 0 : pr_slot + 1;
        if (pr_slot != 0) begin
          pr_prev[pr_slot-1]    = pr_buttons[pr_slot-1];
          pr_buttons[pr_slot-1] = ~item.data_in;
          pr_clock = 1'b1;
        end else begin
          pr_latch = 1'b1;
        end
      end else if (pr_slot == 0) begin
        pr_latch = 1'b0;
      end else begin
        pr_clock = 1'b0;
      end
      pr_last = item.time_us;
    end
    diff          = pr_buttons ^ pr_prev;
    res.latch_out = pr_latch;
    res.clock_out = pr_clock;
    res.buttons   = pr_buttons[OutButtonsW-1:0];
    res.changed   = diff[OutButtonsW-1:0];
    return res;
  endfunction

  // receiver: random stalls, or a counted hold-off when requested
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_start) begin
      out_stall_i <= 1'b1;
      hold_left   <= HoldCycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected result latch=%0b clock=%0b buttons=%02h changed=%02h",
                 $realtime, out_data_o.latch_out, out_data_o.clock_out,
                 out_data_o.buttons, out_data_o.changed);
        mismatch_count++;
      end else begin
        want_report = expected_reports.pop_front();
        if (out_data_o !== want_report) begin
          $display("%0t: mismatch expected latch=%0b clock=%0b buttons=%02h changed=%02h",
                   $realtime, want_report.latch_out, want_report.clock_out,
                   want_report.buttons, want_report.changed);
          $display("%0t:          actual   latch=%0b clock=%0b buttons=%02h changed=%02h",
                   $realtime, out_data_o.latch_out, out_data_o.clock_out,
                   out_data_o.buttons, out_data_o.changed);
          mismatch_count++;
        end
      end
    end
  end

  task automatic send_item(input logic [TimeW-1:0] t, input logic d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    in_data_i.time_us <= t;
    in_data_i.data_in <= d;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_reports.push_back(poll_step(in_t'{time_us: t, data_in: d}));
    poll_now = t;
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_period(input logic [PeriodW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PeriodAddr;
    pwdata  <= ApbDataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pr_period = value;
  endtask

  task automatic test_directed;
    logic [TimeW-1:0] t;
    // reset period: a time equal to the threshold does not toggle
    write_period(PeriodReset);
    send_item(32'd12, 1'b0);
    send_item(32'd13, 1'b0);
    send_item(32'd13, 1'b1);
    drain();
    // zero period: one full latch and button cycle across the time wrap
    write_period('0);
    t = 32'hFFFF_FFF7;
    repeat (18) begin
      send_item(t, 1'($urandom_range(1)));
      t = t + 1;
    end
    send_item(pr_last, 1'b0);
    drain();
    // widest period: equal to threshold across the wrap, then just over it
    write_period(16'hFFFF);
    send_item(32'hFFFF_C000, 1'b1);
    send_item(32'h0000_3FFF, 1'b0);
    send_item(32'h0000_4000, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b1);
    drain();
  endtask

  task automatic test_random_poll(input int unsigned count);
    logic [TimeW-1:0] thr;
    logic [TimeW-1:0] t;
    int unsigned      pick;
    repeat (count) begin
      thr  = TimeW'(pr_period >> 1);
      pick = $urandom_range(99);
      if (pick < 5) t = $urandom();
      else if (pick < 12) t = pr_last + thr;
      else t = poll_now + TimeW'($urandom_range(0, thr + 1));
      send_item(t, 1'($urandom_range(1)));
    end
    drain();
  endtask

  task automatic test_period_sweep(input int unsigned per_period);
    logic [PeriodW-1:0] periods[9];
    periods = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd24, 16'hFFFF, 16'hFFFE,
                PeriodW'($urandom_range(4, 200)), PeriodW'($urandom_range(0, 65535))};
    foreach (periods[i]) begin
      write_period(periods[i]);
      test_random_poll(per_period);
    end
  endtask

  task automatic test_backpressure;
    write_period(16'd2);
    @(posedge clk_i);
    hold_start <= 1'b1;
    @(posedge clk_i);
    hold_start <= 1'b0;
    test_random_poll(40);
  endtask

  initial begin
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    pr_period   = PeriodReset;
    pr_last     = '0;
    pr_phase    = 1'b0;
    pr_slot     = 0;
    pr_buttons  = '0;
    pr_prev     = '0;
    pr_latch    = 1'b0;
    pr_clock    = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct  = 24;
    recv_stall_pct = 74;
    test_directed();
    test_period_sweep(30);

    send_idle_pct  = 74;
    recv_stall_pct = 24;
    test_period_sweep(30);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_backpressure();
    test_period_sweep(30);

    drain();
    if (mismatch_count == 0) begin
      $display("serial_gamepad_poller_tb: clean");
    end else begin
      $display("serial_gamepad_poller_tb: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("serial_gamepad_poller_tb: errors");
    $finish;
  end

endmodule
